// ===== rtl/priority_ready_queue_scheduler_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the priority ready queue scheduler
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is asserted
`define PRQS_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// clocked check, active during reset too
`define PRQS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define PRQS_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define PRQS_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

// ===== rtl/prqs_pkg.sv =====
// ---------------------------------------------------------------------------
// prqs_pkg
// Types and codes shared by the priority ready queue scheduler.
// ---------------------------------------------------------------------------
package prqs_pkg;

  localparam int unsigned ID_W   = 4;
  localparam int unsigned PRIO_W = 8;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  localparam logic [1:0] OUTCOME_DONE  = 2'd0;
  localparam logic [1:0] OUTCOME_FULL  = 2'd1;
  localparam logic [1:0] OUTCOME_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_POP,
    ST_INS,
    ST_CMP,
    ST_PUT,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/priority_ready_queue_scheduler_core.sv =====
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler_core
// Priority-sorted ready queue with a running-task slot.
// ---------------------------------------------------------------------------
// The queue lives in a circular buffer memory with one write and one registered
// read port, kept sorted by priority (highest at the head, ties in arrival
// order). One item is worked at a time and in_tready is high only while idle.
// A dropped insert, a schedule with nothing waiting and a requeue onto an empty
// queue go straight to the finish state. A schedule that pops passes through
// accept, head read and pop. An insert into an empty queue writes its slot
// with no walk. Any other insert reads the tail and then walks each waiting
// entry with a lower priority from the tail through a single 8-bit priority
// comparator, shifting it back one slot. A requeue on schedule is a pop
// followed by such an insert. When the running task outranks the head, the
// requeue ends after the compare. A finished result waits in the output
// register while the next word is already accepted. A result that is still
// waiting there when the next one is finished holds the block for as long as
// the output stalls.
// ---------------------------------------------------------------------------
`include "priority_ready_queue_scheduler_core_assert.svh"

module priority_ready_queue_scheduler_core
  import prqs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // task_id[3:0], task_priority[11:4], still_ready[12]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // next_task[3:0], next_valid[4], outcome[6:5],
                                  // queue_count[11:7]
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // physical slot of a logical queue position
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [ID_W-1:0]   cur_id_r, cur_id_nxt;
  logic [PRIO_W-1:0] cur_prio_r, cur_prio_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  entry_t            ins_r, ins_nxt;
  logic              op_r, op_nxt;
  logic              req_r, req_nxt;
  logic [1:0]        outcome_r, outcome_nxt;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [ID_W-1:0]   out_task_r;
  logic              out_run_r;
  logic [1:0]        out_outcome_r;
  logic [4:0]        out_count_r;

  entry_t            mem [QUEUE_DEPTH];
  entry_t            rd_data_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     wr_addr, rd_addr;
  entry_t            wr_data;

  logic              in_acc, out_free, cmp_ge;
  logic [PRIO_W-1:0] cmp_ref;
  logic [CW+4:0]     count_ext;

  logic              a_op;
  logic [ID_W-1:0]   a_id;
  logic [PRIO_W-1:0] a_prio;
  logic              a_ready;

  assign a_op    = in_tuser[0];
  assign a_id    = in_tdata[3:0];
  assign a_prio  = in_tdata[11:4];
  assign a_ready = in_tdata[12];

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // shared comparator: head against running task on pop, walked entry against
  // the task being placed otherwise
  assign cmp_ref = (state_r == ST_POP) ? cur_prio_r : ins_r.prio;
  assign cmp_ge  = (rd_data_r.prio >= cmp_ref);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (a_op == OP_INSERT) begin
            state_nxt = (count_r == FULL_CNT) ? ST_FIN : ST_INS;
          end else if (a_ready && cur_valid_r) begin
            state_nxt = (count_r == '0) ? ST_FIN : ST_HEAD;
          end else begin
            state_nxt = (count_r == '0) ? ST_FIN : ST_HEAD;
          end
        end
      end
      ST_HEAD: state_nxt = ST_POP;
      ST_POP: begin
        state_nxt = (req_r && cmp_ge) ? ST_INS : ST_FIN;
      end
      ST_INS: state_nxt = (count_r == '0) ? ST_FIN : ST_CMP;
      ST_CMP: begin
        if (cmp_ge) state_nxt = ST_FIN;
        else if (k_r == AW'(1)) state_nxt = ST_PUT;
        else state_nxt = ST_CMP;
      end
      ST_PUT: state_nxt = ST_FIN;
      ST_FIN: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    k_nxt          = k_r;
    cur_id_nxt     = cur_id_r;
    cur_prio_nxt   = cur_prio_r;
    cur_valid_nxt  = cur_valid_r;
    ins_nxt        = ins_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    outcome_nxt    = outcome_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    wr_addr        = head_r;
    wr_data        = ins_r;
    rd_addr        = head_r;
    in_tready      = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = a_op;
          ins_nxt.id  = a_id;
          ins_nxt.prio = a_prio;
          req_nxt     = a_ready && cur_valid_r;
          outcome_nxt = OUTCOME_DONE;
          if (a_op == OP_INSERT) begin
            if (count_r == FULL_CNT) outcome_nxt = OUTCOME_FULL;
          end else if (!(a_ready && cur_valid_r) && count_r == '0) begin
            cur_valid_nxt = 1'b0;
            cur_id_nxt    = '0;
            cur_prio_nxt  = '0;
            outcome_nxt   = OUTCOME_EMPTY;
          end
        end
      end
      ST_HEAD: begin
        mem_re  = 1'b1;
        rd_addr = head_r;
      end
      ST_POP: begin
        // requeue only swaps when the head is at least as urgent
        if (!req_r || cmp_ge) begin
          cur_id_nxt    = rd_data_r.id;
          cur_prio_nxt  = rd_data_r.prio;
          cur_valid_nxt = 1'b1;
          head_nxt      = wrap_add(head_r, AW'(1));
          count_nxt     = count_r - CW'(1);
          if (req_r) begin
            ins_nxt.id   = cur_id_r;
            ins_nxt.prio = cur_prio_r;
          end
        end
      end
      ST_INS: begin
        if (count_r == '0) begin
          mem_we    = 1'b1;
          wr_addr   = head_r;
          wr_data   = ins_r;
          count_nxt = count_r + CW'(1);
        end else begin
          mem_re  = 1'b1;
          rd_addr = wrap_add(head_r, AW'(count_r - CW'(1)));
          k_nxt   = AW'(count_r);
        end
      end
      ST_CMP: begin
        mem_we  = 1'b1;
        wr_addr = wrap_add(head_r, k_r);
        if (cmp_ge) begin
          wr_data   = ins_r;
          count_nxt = count_r + CW'(1);
        end else begin
          // lower priority entry moves back one slot
          wr_data = rd_data_r;
          k_nxt   = k_r - AW'(1);
          if (k_r != AW'(1)) begin
            mem_re  = 1'b1;
            rd_addr = wrap_add(head_r, k_r - AW'(2));
          end
        end
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        wr_addr   = head_r;
        wr_data   = ins_r;
        count_nxt = count_r + CW'(1);
      end
      ST_FIN: begin
        if (out_free) out_tvalid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign count_ext = {5'b0, count_r};

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      head_r       <= '0;
      cur_id_r     <= '0;
      cur_prio_r   <= '0;
      cur_valid_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      cur_id_r     <= cur_id_nxt;
      cur_prio_r   <= cur_prio_nxt;
      cur_valid_r  <= cur_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    ins_r     <= ins_nxt;
    op_r      <= op_nxt;
    req_r     <= req_nxt;
    outcome_r <= outcome_nxt;
    if (state_r == ST_FIN && out_free) begin
      out_task_r    <= cur_id_r;
      out_run_r     <= cur_valid_r;
      out_outcome_r <= outcome_r;
      out_count_r   <= count_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_count_r, out_outcome_r, out_run_r, out_task_r};

  // ---------------- checks ----------------
  `PRQS_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL_CNT, "queue count above depth")
  `PRQS_ASSERT(a_count_step, clk, rst_n, (count_r != $past(count_r)) |-> ((count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1))), "queue count jumped")
  `PRQS_ASSERT(a_walk_slot, clk, rst_n, (state_r == ST_CMP) |-> ((k_r != '0) && ({1'b0, k_r} <= {1'b0, count_r})), "walk slot out of range")
  `PRQS_ASSERT(a_empty_idle, clk, rst_n, (out_tvalid_r && out_outcome_r == OUTCOME_EMPTY) |-> (!out_run_r && out_task_r == '0), "empty schedule reports a running task")
  `PRQS_ASSERT(a_full_drop, clk, rst_n, (state_r == ST_FIN && op_r == OP_INSERT && outcome_r == OUTCOME_FULL) |-> (count_r == FULL_CNT), "dropped insert without full queue")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - priority ready queue scheduler core
// Sends insert and schedule words through the input stream, predicts each
// result with a local sorted-queue model and checks every result word
// field by field. Runs directed corner cases, a fill-to-full pass, and
// random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import prqs_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    logic [3:0] next_task;
    logic       next_valid;
    logic [1:0] outcome;
    logic [4:0] queue_count;
  } sched_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // task_id[3:0], task_priority[11:4], still_ready[12]
  logic [0:0]  in_tuser   = '0;   // operation[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // next_task[3:0], next_valid[4], outcome[6:5],
                                  // queue_count[11:7]

  // local copy of the scheduler state
  logic [3:0] ready_ids [QDEPTH];
  logic [7:0] ready_prio[QDEPTH];
  int         ready_count;
  logic [3:0] run_id;
  logic [7:0] run_prio;
  logic       run_valid;

  sched_result_t pending_results[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;

  priority_ready_queue_scheduler_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic void sched_reset();
    ready_count = 0;
    run_id      = '0;
    run_prio    = '0;
    run_valid   = 1'b1;
  endfunction

  // place after every entry of equal or higher priority
  function automatic void queue_put(logic [3:0] id, logic [7:0] prio);
    int pos;
    pos = 0;
    while (pos < ready_count && ready_prio[pos] >= prio) pos++;
    for (int k = ready_count; k > pos; k--) begin
      ready_ids[k]  = ready_ids[k-1];
      ready_prio[k] = ready_prio[k-1];
    end
    ready_ids[pos]  = id;
    ready_prio[pos] = prio;
    ready_count++;
  endfunction

  function automatic void queue_pop_to_run();
    run_id    = ready_ids[0];
    run_prio  = ready_prio[0];
    run_valid = 1'b1;
    for (int k = 0; k + 1 < ready_count; k++) begin
      ready_ids[k]  = ready_ids[k+1];
      ready_prio[k] = ready_prio[k+1];
    end
    ready_count--;
  endfunction

  function automatic sched_result_t sched_step(logic op, logic [3:0] id, logic [7:0] prio,
                                               logic still_ready);
    sched_result_t r;
    logic [3:0]    old_id;
    logic [7:0]    old_prio;
    r.outcome = OUTCOME_DONE;
    if (op == OP_INSERT) begin
      if (ready_count >= QDEPTH) r.outcome = OUTCOME_FULL;
      else queue_put(id, prio);
    end else if (still_ready && run_valid) begin
      // a running task strictly above the head would just come straight back
      if (ready_count > 0 && run_prio <= ready_prio[0]) begin
        old_id   = run_id;
        old_prio = run_prio;
        queue_pop_to_run();
        queue_put(old_id, old_prio);
      end
    end else if (ready_count > 0) begin
      queue_pop_to_run();
    end else begin
      run_valid = 1'b0;
      run_id    = '0;
      run_prio  = '0;
      r.outcome = OUTCOME_EMPTY;
    end
    r.next_task   = run_valid ? run_id : 4'd0;
    r.next_valid  = run_valid;
    r.queue_count = 5'(ready_count);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, want);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[3:0] !== want.next_task)
          report_mismatch("next_task", out_tdata[3:0], want.next_task);
        if (out_tdata[4] !== want.next_valid)
          report_mismatch("next_valid", out_tdata[4], want.next_valid);
        if (out_tdata[6:5] !== want.outcome)
          report_mismatch("outcome", out_tdata[6:5], want.outcome);
        if (out_tdata[11:7] !== want.queue_count)
          report_mismatch("queue_count", out_tdata[11:7], want.queue_count);
        if (out_tdata[15:12] !== 4'd0)
          report_mismatch("pad bits", out_tdata[15:12], 16'h0);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // entered and left at a falling edge; tvalid stays high on return so that
  // back-to-back words need no extra assignment in the same step
  task automatic send_word(logic op, logic [3:0] id, logic [7:0] prio, logic still_ready);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, still_ready, prio, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(sched_step(op, id, prio, still_ready));
    @(negedge clk);
  endtask

  task automatic insert_task(logic [3:0] id, logic [7:0] prio);
    send_word(OP_INSERT, id, prio, 1'($urandom_range(1)));
  endtask

  task automatic schedule(logic still_ready);
    send_word(OP_SCHEDULE, 4'($urandom_range(15)), 8'($urandom_range(255)), still_ready);
  endtask

  // hold off the sender until every result is back, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (QDEPTH + 8) @(negedge clk);
  endtask

  task automatic test_directed();
    schedule(1'b1);             // requeue into empty queue: task 0 keeps running
    schedule(1'b0);             // nothing to run
    schedule(1'b1);             // requeue with no running task
    insert_task(4'd15, 8'd255);
    insert_task(4'd0, 8'd0);
    insert_task(4'd7, 8'd255);  // tie, goes behind id 15
    insert_task(4'd15, 8'd128); // duplicate id
    schedule(1'b0);
    schedule(1'b1);             // equal priority: swaps with head
    insert_task(4'd7, 8'd100);  // same id as the running task
    schedule(1'b1);
    schedule(1'b0);
    insert_task(4'd3, 8'd0);
    schedule(1'b1);
    repeat (6) schedule(1'b0);  // drain to empty, then empty twice
    drain();
  endtask

  task automatic test_full_queue();
    insert_task(4'd9, 8'd250);
    schedule(1'b0);
    repeat (QDEPTH) insert_task(4'($urandom_range(15)), 8'($urandom_range(1, 200)));
    insert_task(4'd0, 8'd255);  // dropped
    schedule(1'b1);             // requeue on full queue, running task stays
    insert_task(4'd15, 8'd0);   // dropped
    schedule(1'b0);
    insert_task(4'd3, 8'd255);
    schedule(1'b1);             // requeue on full queue, head takes over
    repeat (QDEPTH + 1) schedule(1'b0);
    drain();
  endtask

  // bursts with a drifting insert mix so the queue swings between empty and full
  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    int         burst = 0;
    int         fill_pct = 50;
    bit         narrow = 1'b0;
    logic [7:0] prio;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(10, 60);
        case ($urandom_range(2))
          0:       fill_pct = 25;
          1:       fill_pct = 50;
          default: fill_pct = 80;
        endcase
        narrow = 1'($urandom_range(1));
      end
      burst--;
      prio = narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      if ($urandom_range(99) < fill_pct)
        send_word(OP_INSERT, 4'($urandom_range(15)), prio, 1'($urandom_range(1)));
      else
        send_word(OP_SCHEDULE, 4'($urandom_range(15)), prio, 1'($urandom_range(1)));
    end
    drain();
  endtask

  initial begin
    sched_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    recv_stall_pct = 0;
    test_directed();
    test_full_queue();
    test_random(400, 0, 0);
    test_random(380, 73, 0);
    test_random(380, 0, 73);
    test_random(380, 18, 18);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
